### hdl/ctc_greedy_decoder_unit_assert.svh
// assertion macros for the ctc greedy decoder
`ifndef CTC_GREEDY_DECODER_UNIT_ASSERT_SVH
`define CTC_GREEDY_DECODER_UNIT_ASSERT_SVH

// plain property, sampled on clk, off while reset is asserted
`define CTCG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define CTCG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ctcg_pkg.sv
// package: widths, codes and shared types of the ctc greedy decoder
`default_nettype none

package ctcg_pkg;

	localparam int MAX_CLASSES = 8192;
	localparam int TABLE_AW    = $clog2(MAX_CLASSES);

	localparam int SCORE_W   = 16;
	localparam int CLASS_W   = 13;
	localparam int PREV_W    = 14;
	localparam int CHARSET_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [PREV_W-1:0]  NONE_WINNER = '1;
	localparam logic [CLASS_W-1:0] COUNTER_MAX = '1;

	// item commands
	localparam logic CMD_SCORE = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PROB = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARSET  = 2'd1;

	localparam logic [CHARSET_W-1:0] CHARSET_RESET = 14'd8192;

	typedef struct packed {
		logic [SCORE_W-1:0]   min_probability;
		logic [CHARSET_W-1:0] charset_size;
	} cfg_regs_t;

	// winner of a finished row on its way to the table lookup
	typedef struct packed {
		logic [CLASS_W-1:0] winner;
		logic               pre_ok;
		logic               seq_end;
	} rowend_t;

endpackage

`default_nettype wire

### hdl/ctcg_in_if.sv
// input item channel
`default_nettype none

interface ctcg_in_if;
	import ctcg_pkg::*;
	logic               valid;
	logic               ready;
	logic               command;
	logic [SCORE_W-1:0] score;
	logic               row_end;
	logic               sequence_end;
	logic [CLASS_W-1:0] load_class;
	logic               load_allowed;

	modport source (output valid, command, score, row_end, sequence_end, load_class,
		load_allowed, input ready);
	modport sink (input valid, command, score, row_end, sequence_end, load_class,
		load_allowed, output ready);
endinterface

`default_nettype wire

### hdl/ctcg_out_if.sv
// result channel
`default_nettype none

interface ctcg_out_if;
	import ctcg_pkg::*;
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] char_index;
	logic               char_valid;
	logic               sequence_done;

	modport source (output valid, char_index, char_valid, sequence_done, input ready);
	modport sink (input valid, char_index, char_valid, sequence_done, output ready);
endinterface

`default_nettype wire

### hdl/ctcg_cfg_if.sv
// configuration write channel
`default_nettype none

interface ctcg_cfg_if;
	import ctcg_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/ctcg_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ctcg_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/ctcg_row_argmax.sv
// running argmax over one row and previous-winner tracking
`default_nettype none

module ctcg_row_argmax import ctcg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_regs_t          cfg,
	input  wire logic               accept,
	input  wire logic [SCORE_W-1:0] score,
	input  wire logic               row_end,
	input  wire logic               seq_end,
	output rowend_t                 rowend
);

	logic [SCORE_W-1:0] best_score_q;
	logic [CLASS_W-1:0] best_class_q;
	logic [CLASS_W-1:0] cnt_q;
	logic [PREV_W-1:0]  prev_q;

	logic               take;
	logic [CLASS_W-1:0] win_class;
	logic [SCORE_W-1:0] win_score;

	// first class loads, later ones only when strictly greater
	always_comb begin
		take      = (cnt_q == '0) || (score > best_score_q);
		win_class = take ? cnt_q : best_class_q;
		win_score = take ? score : best_score_q;
	end

	// checks that need no table lookup
	always_comb begin
		rowend.winner  = win_class;
		rowend.seq_end = seq_end;
		rowend.pre_ok  = (win_class != '0) &&
			({1'b0, win_class} != prev_q) &&
			({1'b0, win_class} < cfg.charset_size) &&
			(win_score >= cfg.min_probability);
	end

	// row state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
			cnt_q        <= '0;
			prev_q       <= NONE_WINNER;
		end else if (accept) begin
			if (row_end) begin
				best_score_q <= '0;
				best_class_q <= '0;
				cnt_q        <= '0;
				prev_q       <= seq_end ? NONE_WINNER : {1'b0, win_class};
			end else begin
				best_score_q <= win_score;
				best_class_q <= win_class;
				if (cnt_q != COUNTER_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hdl/ctc_greedy_decoder_unit.sv
// top level of the ctc greedy decoder
// Greedy CTC decoder. Class probabilities (unsigned Q0.16) arrive on the item
// channel one per transaction, in class order, row_end on the last class of a
// time step and sequence_end on the last row end of a sequence. Items with
// command set write one allowed bit of the 8192-entry class table.
// The block takes one item per cycle while item ready is high. A row end
// reads the allowed bit of the winner from the table ram into the lookup
// stage, and a character or sequence_done result is registered in the output
// stage. Rows that give no character and no sequence end give no result.
// Configuration writes (min_probability, charset_size) go through the cfg
// channel, which is always ready; the user must make them while the block
// is idle, which the block does not enforce. After reset the table is swept
// clear one entry per cycle with item ready low. Row state restarts and
// previous winner is cleared. When the result receiver stalls, the output
// register holds its result and one more finished row may wait in the lookup
// stage; item ready drops only when that row also has a result to deliver.
`default_nettype none

module ctc_greedy_decoder_unit import ctcg_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	ctcg_in_if.sink   item,
	ctcg_out_if.source result,
	ctcg_cfg_if.sink  cfg
);

	cfg_regs_t cfg_q;

	logic                clr_done_q;
	logic [TABLE_AW-1:0] clr_idx_q;

	logic      in_acc;
	logic      score_acc;
	rowend_t   rowend;
	rowend_t   s1_q;
	logic      s1_valid_q;
	logic      s1_has_result;
	logic      s1_adv;

	logic                ram_we;
	logic [TABLE_AW-1:0] ram_waddr;
	logic [0:0]          ram_wdata;
	logic                ram_re;
	logic [0:0]          ram_rdata;

	logic               out_valid_q;
	logic [CLASS_W-1:0] out_index_q;
	logic               out_char_q;
	logic               out_done_q;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_probability <= '0;
			cfg_q.charset_size    <= CHARSET_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_PROB: cfg_q.min_probability <= cfg.data;
				REG_CHARSET:  cfg_q.charset_size    <= cfg.data[CHARSET_W-1:0];
				default: ;
			endcase
		end
	end

	// table clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// input handshake
	assign s1_has_result = s1_q.seq_end || (s1_q.pre_ok && ram_rdata[0]);
	assign s1_adv        = !s1_valid_q || !s1_has_result || !out_valid_q || result.ready;
	assign item.ready    = clr_done_q && s1_adv;
	assign in_acc        = item.valid && item.ready;
	assign score_acc     = in_acc && (item.command == CMD_SCORE);

	ctcg_row_argmax u_argmax (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (score_acc),
		.score   (item.score),
		.row_end (item.row_end),
		.seq_end (item.sequence_end),
		.rowend  (rowend)
	);

	// allowed-bit table: loads and sweep write, row ends read
	assign ram_we    = !clr_done_q || (in_acc && (item.command == CMD_LOAD));
	assign ram_waddr = clr_done_q ? item.load_class[TABLE_AW-1:0] : clr_idx_q;
	assign ram_wdata = clr_done_q ? item.load_allowed : 1'b0;
	assign ram_re    = score_acc && item.row_end;

	ctcg_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CLASSES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rowend.winner[TABLE_AW-1:0]),
		.rdata (ram_rdata)
	);

	// lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ram_re) begin
			s1_q <= rowend;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_has_result && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_has_result && s1_adv) begin
			out_char_q  <= s1_q.pre_ok && ram_rdata[0];
			out_index_q <= (s1_q.pre_ok && ram_rdata[0]) ? s1_q.winner : '0;
			out_done_q  <= s1_q.seq_end;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.char_index    = out_index_q;
	assign result.char_valid    = out_char_q;
	assign result.sequence_done = out_done_q;

`include "ctc_greedy_decoder_unit_assert.svh"

	// a delivered character never carries the blank class
	`CTCG_ASSERT_IMP(a_no_blank, out_valid_q && out_char_q, out_index_q != '0, "blank class emitted")
	// every result closes a sequence or carries a character
	`CTCG_ASSERT_IMP(a_result_kind, out_valid_q, out_char_q || out_done_q, "empty result offered")
	// no table lookup while the clearing sweep runs
	`CTCG_ASSERT_IMP(a_no_read_in_clear, ram_re, clr_done_q, "table read during clear")
	// a row end taken in always reaches the lookup stage
	`CTCG_ASSERT_NEXT(a_rowend_to_s1, ram_re, s1_valid_q, "row end lost before lookup")

endmodule

`default_nettype wire

### sim/tb_ctc_greedy_decoder_unit.sv
// testbench for the ctc greedy decoder: queued stimulus, in-line decoder prediction, result checks
`default_nettype none

module tb_ctc_greedy_decoder_unit;
	import ctcg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE      = 8;
	localparam int HOLDOFF     = 400;
	localparam int MAX_PRINTS  = 40;

	typedef struct {
		logic               command;
		logic [SCORE_W-1:0] score;
		logic               row_end;
		logic               sequence_end;
		logic [CLASS_W-1:0] load_class;
		logic               load_allowed;
	} item_t;

	typedef struct {
		logic [CLASS_W-1:0] char_index;
		logic               char_valid;
		logic               sequence_done;
	} char_t;

	typedef struct {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	ctcg_in_if  item_ch ();
	ctcg_out_if result_ch ();
	ctcg_cfg_if cfg_ch ();

	ctc_greedy_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	item_t      items_to_send[$];
	char_t      expected_chars[$];
	reg_write_t reg_writes[$];

	int          items_queued;
	int          mismatches;
	logic        send_quiet;
	logic        recv_quiet;
	logic        pressure_go;
	logic        hold_results;
	int unsigned send_gap;
	int unsigned take_gap;

	// decoder mirror: settings, row state and class table
	logic [SCORE_W-1:0]   min_prob_cfg;
	logic [CHARSET_W-1:0] charset_cfg;
	logic [SCORE_W-1:0]   best_score;
	logic [CLASS_W-1:0]   best_class;
	logic [CLASS_W-1:0]   class_count;
	logic [PREV_W-1:0]    last_winner;
	bit                   allowed_bits [MAX_CLASSES];

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t: %s", $time, msg);
	endtask

	// greedy decode of one accepted transaction into the expected characters
	task automatic decode_step(input item_t it);
		logic [CLASS_W-1:0] winner;
		logic               emit;
		char_t              c;
		if (it.command == CMD_LOAD) begin
			allowed_bits[it.load_class] = it.load_allowed;
			return;
		end
		// running argmax, the first maximum stays on a tie
		if (class_count == '0 || it.score > best_score) begin
			best_score = it.score;
			best_class = class_count;
		end
		if (class_count != COUNTER_MAX)
			class_count = class_count + 1'b1;
		if (!it.row_end)
			return;
		winner = best_class;
		emit = (winner != '0) && ({1'b0, winner} != last_winner) &&
			({1'b0, winner} < charset_cfg) && (best_score >= min_prob_cfg) &&
			allowed_bits[winner];
		last_winner = it.sequence_end ? NONE_WINNER : {1'b0, winner};
		best_score = '0;
		best_class = '0;
		class_count = '0;
		if (emit || it.sequence_end) begin
			c.char_index = emit ? winner : '0;
			c.char_valid = emit;
			c.sequence_done = it.sequence_end;
			expected_chars.insert(expected_chars.size(), c);
		end
	endtask

	task automatic queue_score(input logic [SCORE_W-1:0] s, input logic re, input logic se);
		item_t it;
		it.command = CMD_SCORE;
		it.score = s;
		it.row_end = re;
		it.sequence_end = se;
		it.load_class = CLASS_W'($urandom_range(0, MAX_CLASSES - 1));
		it.load_allowed = 1'($urandom_range(0, 1));
		items_to_send.insert(items_to_send.size(), it);
		items_queued++;
	endtask

	task automatic queue_load(input logic [CLASS_W-1:0] cls, input logic allow);
		item_t it;
		it.command = CMD_LOAD;
		it.score = SCORE_W'($urandom());
		it.row_end = 1'($urandom_range(0, 1));
		it.sequence_end = 1'($urandom_range(0, 1));
		it.load_class = cls;
		it.load_allowed = allow;
		items_to_send.insert(items_to_send.size(), it);
		items_queued++;
	endtask

	task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		reg_write_t w;
		w.index = idx;
		w.data = val;
		reg_writes.insert(reg_writes.size(), w);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (items_to_send.size() != 0 || item_ch.valid || expected_chars.size() != 0 ||
			reg_writes.size() != 0 || cfg_ch.valid);
		// rows without a result may still sit in the lookup stage
		repeat (SETTLE) @(negedge clk);
	endtask

	// clock
	initial begin : clock_gen
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ctc_greedy_decoder_unit: mismatch");
		$finish;
	end

	// item driver with a random gap after each transaction unless send_quiet is set
	always @(posedge clk or negedge arst_n) begin : item_driver
		item_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_gap <= 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				item_ch.valid <= 1'b0;
			end else if (items_to_send.size() != 0) begin
				nxt = items_to_send.pop_front();
				item_ch.command <= nxt.command;
				item_ch.score <= nxt.score;
				item_ch.row_end <= nxt.row_end;
				item_ch.sequence_end <= nxt.sequence_end;
				item_ch.load_class <= nxt.load_class;
				item_ch.load_allowed <= nxt.load_allowed;
				item_ch.valid <= 1'b1;
				send_gap <= send_quiet ? 0 : $urandom_range(0, 8);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// register writer, mirror follows each write transaction
	always @(posedge clk or negedge arst_n) begin : reg_writer
		reg_write_t w;
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
		end else if (!cfg_ch.valid || cfg_ch.ready) begin
			if (cfg_ch.valid) begin
				if (cfg_ch.index == REG_MIN_PROB)
					min_prob_cfg = cfg_ch.data;
				else if (cfg_ch.index == REG_CHARSET)
					charset_cfg = cfg_ch.data[CHARSET_W-1:0];
			end
			if (reg_writes.size() != 0) begin
				w = reg_writes.pop_front();
				cfg_ch.index <= w.index;
				cfg_ch.data <= w.data;
				cfg_ch.valid <= 1'b1;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls unless recv_quiet is set, and the long hold-off
	always @(posedge clk or negedge arst_n) begin : result_taker
		int unsigned g;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			take_gap <= 0;
		end else if (hold_results) begin
			result_ch.ready <= 1'b0;
		end else if (result_ch.valid && result_ch.ready) begin
			g = recv_quiet ? 0 : $urandom_range(0, 8);
			take_gap <= g;
			result_ch.ready <= (g == 0);
		end else if (take_gap != 0) begin
			take_gap <= take_gap - 1;
			result_ch.ready <= (take_gap == 1);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// long receiver hold-off while items keep coming
	initial begin : result_holdoff
		hold_results = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLDOFF) @(posedge clk);
		hold_results <= 1'b0;
	end

	// accepted items feed the prediction
	always @(posedge clk) begin : item_monitor
		item_t seen;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			seen.command = item_ch.command;
			seen.score = item_ch.score;
			seen.row_end = item_ch.row_end;
			seen.sequence_end = item_ch.sequence_end;
			seen.load_class = item_ch.load_class;
			seen.load_allowed = item_ch.load_allowed;
			decode_step(seen);
		end
	end

	// each result transaction against the oldest expected character
	always @(posedge clk) begin : result_monitor
		char_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected result index %0d valid %b done %b",
					result_ch.char_index, result_ch.char_valid, result_ch.sequence_done));
			end else begin
				want = expected_chars.pop_front();
				if (result_ch.char_index !== want.char_index)
					flag_mismatch($sformatf("char_index %0d, predicted %0d",
						result_ch.char_index, want.char_index));
				if (result_ch.char_valid !== want.char_valid)
					flag_mismatch($sformatf("char_valid %b, predicted %b",
						result_ch.char_valid, want.char_valid));
				if (result_ch.sequence_done !== want.sequence_done)
					flag_mismatch($sformatf("sequence_done %b, predicted %b",
						result_ch.sequence_done, want.sequence_done));
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int n;
		int peak_at;
		int fav;
		int rows;
		int phase_start;
		logic [SCORE_W-1:0] peak;
		logic [SCORE_W-1:0] s;
		// known levels from time zero
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_SCORE;
		item_ch.score = '0;
		item_ch.row_end = 1'b0;
		item_ch.sequence_end = 1'b0;
		item_ch.load_class = '0;
		item_ch.load_allowed = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MIN_PROB;
		cfg_ch.data = '0;
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		pressure_go = 1'b0;
		items_queued = 0;
		mismatches = 0;
		min_prob_cfg = '0;
		charset_cfg = CHARSET_RESET;
		best_score = '0;
		best_class = '0;
		class_count = '0;
		last_winner = NONE_WINNER;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows under reset settings, table cleared
		@(negedge clk);
		queue_score(16'd0, 1'b1, 1'b1);
		// sequence end without row end is ignored; tie keeps class 0
		queue_score(16'hFFFF, 1'b0, 1'b1);
		queue_score(16'hFFFF, 1'b1, 1'b0);
		queue_load(13'd1, 1'b1);
		queue_load(13'd8191, 1'b1);
		queue_load(13'd5, 1'b1);
		queue_load(13'd5, 1'b0);
		queue_load(13'd6, 1'b1);
		// class 1 wins a tie with class 2
		queue_score(16'd100, 1'b0, 1'b0);
		queue_score(16'd200, 1'b0, 1'b0);
		queue_score(16'd200, 1'b1, 1'b0);
		// same winner again, suppressed
		queue_score(16'd0, 1'b0, 1'b0);
		queue_score(16'hFFFF, 1'b1, 1'b0);
		// blank row, then class 1 counts as new
		queue_score(16'hFFFF, 1'b1, 1'b0);
		queue_score(16'd7, 1'b0, 1'b0);
		queue_score(16'd9, 1'b1, 1'b0);
		// class 5 not allowed, closes the sequence with no character
		for (int k = 0; k < 6; k++)
			queue_score((k == 5) ? 16'd1 : 16'd0, k == 5, k == 5);
		// class 6 right after a sequence end
		for (int k = 0; k < 7; k++)
			queue_score((k == 6) ? 16'hFFFF : 16'h8000, k == 6, 1'b0);
		wait_idle();

		// random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					queue_reg(REG_MIN_PROB, 16'd0);
					queue_reg(REG_CHARSET, CFG_DAT_W'(CHARSET_RESET));
					send_quiet = 1'b1;
					recv_quiet = 1'b1;
				end
				1: begin
					queue_reg(REG_MIN_PROB, 16'hFFFF);
					queue_reg(REG_CHARSET, CFG_DAT_W'(CHARSET_RESET));
					send_quiet = 1'b0;
					recv_quiet = 1'b1;
				end
				2: begin
					queue_reg(REG_MIN_PROB, CFG_DAT_W'($urandom()));
					queue_reg(REG_CHARSET, 16'd7);
					send_quiet = 1'b0;
					recv_quiet = 1'b0;
				end
				3: begin
					queue_reg(REG_MIN_PROB, 16'd0);
					queue_reg(REG_CHARSET, 16'd0);
					send_quiet = 1'b1;
					recv_quiet = 1'b0;
				end
				4: begin
					queue_reg(REG_MIN_PROB, CFG_DAT_W'($urandom()));
					queue_reg(REG_CHARSET, CFG_DAT_W'($urandom_range(0, 20)));
					send_quiet = 1'b0;
					recv_quiet = 1'b0;
				end
				default: begin
					queue_reg(REG_MIN_PROB, 16'd30000);
					queue_reg(REG_CHARSET, CFG_DAT_W'($urandom_range(0, MAX_CLASSES)));
					send_quiet = 1'b0;
					recv_quiet = 1'b0;
				end
			endcase
			wait_idle();

			phase_start = items_queued;
			// fresh allowed bits for the low classes, a few anywhere
			for (int c = 0; c < 20; c++)
				queue_load(CLASS_W'(c), $urandom_range(0, 3) != 0);
			repeat (3) queue_load(CLASS_W'($urandom_range(0, MAX_CLASSES - 1)),
				1'($urandom_range(0, 1)));
			if (p == 2)
				pressure_go = 1'b1;

			// sequences of rows, a favorite class makes repeats likely
			while (items_queued - phase_start < PHASE_ITEMS) begin
				rows = $urandom_range(1, 6);
				fav = $urandom_range(1, 8);
				for (int r = 0; r < rows; r++) begin
					n = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
					peak_at = $urandom_range(0, 1) ? $urandom_range(0, n - 1) :
						((fav < n) ? fav : n - 1);
					case ($urandom_range(0, 3))
						0: peak = SCORE_W'($urandom());
						1: peak = 16'hFFFF;
						default: peak = SCORE_W'($urandom_range(40000, 65535));
					endcase
					for (int k = 0; k < n; k++) begin
						if (k == peak_at || $urandom_range(0, 3) == 0)
							s = peak;
						else
							s = SCORE_W'($urandom_range(0, peak));
						// table writes may land inside a row
						if ($urandom_range(0, 19) == 0)
							queue_load(CLASS_W'($urandom_range(0, 31)),
								1'($urandom_range(0, 1)));
						queue_score(s, k == n - 1, (k == n - 1) ?
							(r == rows - 1 && $urandom_range(0, 7) != 0) :
							($urandom_range(0, 15) == 0));
					end
				end
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("ctc_greedy_decoder_unit: match");
		else
			$display("ctc_greedy_decoder_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/ctcg_pkg.sv
hdl/ctcg_in_if.sv
hdl/ctcg_out_if.sv
hdl/ctcg_cfg_if.sv
hdl/ctcg_ram.sv
hdl/ctcg_row_argmax.sv
hdl/ctc_greedy_decoder_unit.sv
sim/tb_ctc_greedy_decoder_unit.sv
